[hdl/tsp_pkg.sv]
`default_nettype none
package tsp_pkg;
   localparam int FracBits = 16;
   localparam int RegW = FracBits + 1;
   localparam int InW = FracBits + 2;
   localparam int NumW = 2 * FracBits + 2;
   localparam int QuoW = FracBits + 2;
   localparam logic [RegW-1:0] One = RegW'(1) << FracBits;
   localparam logic [RegW-1:0] VelMax = {RegW{1'b1}};

   localparam logic [1:0] PhaseAccel = 2'd0;
   localparam logic [1:0] PhaseCruise = 2'd1;
   localparam logic [1:0] PhaseDecel = 2'd2;

   localparam logic CsrEaseIn = 1'b0;
   localparam logic CsrEaseOut = 1'b1;

   typedef struct packed {
      logic [1:0] phase;
      logic cfg_err;
      logic span_zero;
   } tag_type;
endpackage
`default_nettype wire

[hdl/trapezoid_speed_profile.sv]
`default_nettype none
// Trapezoidal speed profile with ease-in and ease-out, Q.16 fixed point.
// A time sample is offered on req_time_in with start; it is taken whenever
// busy is low, and busy never rises, so one sample may enter every clock.
// Each beat produces exactly one result beat on rsp_distance, rsp_velocity,
// rsp_phase and rsp_config_error, marked by rsp_valid for one cycle.
// The receiver cannot stall the result channel, so the pipeline never holds.
// The result passes through two chained bit-per-stage dividers: the first
// divides by t1 or (1-t2) (by 1 in cruise), the second by D = 1 + t2 - t1.
// Throughput is one beat per clock.
// Registers ease_in_time (index 0) and ease_out_time (index 1) are written
// through the csr_ channel, always ready; they should only change while no
// beat is in flight. Reset (synchronous, active high) empties the pipeline
// and restores 0.25 and 0.75. A configuration with ease_in_time not below
// ease_out_time yields zero outputs with config_error set.
module trapezoid_speed_profile (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire logic signed [tsp_pkg::InW-1:0] req_time_in,
   output logic                             rsp_valid,
   output logic [tsp_pkg::RegW-1:0]         rsp_distance,
   output logic [tsp_pkg::RegW-1:0]         rsp_velocity,
   output logic [1:0]                       rsp_phase,
   output logic                             rsp_config_error,
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic                        csr_index,
   input  wire logic [tsp_pkg::RegW-1:0]    csr_data
);
   localparam int RegW = tsp_pkg::RegW;
   localparam int NumW = tsp_pkg::NumW;
   localparam int QuoW = tsp_pkg::QuoW;
   localparam int Fb = tsp_pkg::FracBits;

   logic [RegW-1:0] ease_in_ff, ease_out_ff;

   assign busy = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ease_in_ff  <= tsp_pkg::One >> 2;
         ease_out_ff <= RegW'((3 * (1 << Fb)) / 4);
      end else if (csr_valid) begin
         if (csr_index == tsp_pkg::CsrEaseIn) begin
            ease_in_ff <= csr_data;
         end else begin
            ease_out_ff <= csr_data;
         end
      end
   end

   // Stage A: clamp time and registers, choose phase.
   logic [RegW-1:0] t1, t2, tc;
   always_comb begin
      t1 = (ease_in_ff > tsp_pkg::One) ? tsp_pkg::One : ease_in_ff;
      t2 = (ease_out_ff > tsp_pkg::One) ? tsp_pkg::One : ease_out_ff;
      if (req_time_in[tsp_pkg::InW-1]) begin
         tc = '0;
      end else if (req_time_in > $signed({1'b0, tsp_pkg::One})) begin
         tc = tsp_pkg::One;
      end else begin
         tc = RegW'(req_time_in);
      end
   end

   logic             a_v_ff;
   logic [RegW-1:0]  a_t_ff, a_t1_ff, a_t2_ff, a_x_ff, a_span_ff;
   logic [RegW:0]    a_d_ff;
   tsp_pkg::tag_type a_tag_ff;
   always_ff @(posedge clock) begin
      a_t_ff  <= tc;
      a_t1_ff <= t1;
      a_t2_ff <= t2;
      a_d_ff  <= (RegW + 1)'(tsp_pkg::One) + (RegW + 1)'(t2) - (RegW + 1)'(t1);
      a_tag_ff.cfg_err <= t1 >= t2;
      a_tag_ff.span_zero <= t2 == tsp_pkg::One;
      if (tc < t1) begin
         a_tag_ff.phase <= tsp_pkg::PhaseAccel;
         a_x_ff <= tc;
         a_span_ff <= t1;
      end else if (tc < t2) begin
         a_tag_ff.phase <= tsp_pkg::PhaseCruise;
         a_x_ff <= tc;
         a_span_ff <= t1;
      end else begin
         a_tag_ff.phase <= tsp_pkg::PhaseDecel;
         a_x_ff <= tsp_pkg::One - tc;
         a_span_ff <= tsp_pkg::One - t2;
      end
      if (reset) begin
         a_v_ff <= 1'b0;
      end else begin
         a_v_ff <= start;
      end
   end

   // Stage B: products; only the square uses a multiplier, the others are shifts.
   logic             b_v_ff;
   logic [NumW-1:0]  b_sq_ff, b_lin_ff, b_cru_ff;
   logic [RegW-1:0]  b_span_ff;
   logic [RegW:0]    b_d_ff;
   tsp_pkg::tag_type b_tag_ff;
   always_ff @(posedge clock) begin
      b_sq_ff   <= NumW'(a_x_ff) * NumW'(a_x_ff);
      b_lin_ff  <= NumW'(a_x_ff) << (Fb + 1);
      b_cru_ff  <= (NumW'(a_t_ff) << (Fb + 1)) - (NumW'(a_t1_ff) << Fb);
      b_span_ff <= a_span_ff;
      b_d_ff    <= a_d_ff;
      b_tag_ff  <= a_tag_ff;
      if (reset) begin
         b_v_ff <= 1'b0;
      end else begin
         b_v_ff <= a_v_ff;
      end
   end

   // First division: by t1 or span; cruise phase passes through (divides by 1).
   // An empty deceleration span only occurs at the very end of the path, where
   // the numerator is zero and the output stage supplies the result.
   logic cru;
   assign cru = b_tag_ff.phase == tsp_pkg::PhaseCruise;
   logic [RegW:0] den1_sq, den1_lin;
   always_comb begin
      den1_sq  = (cru || b_span_ff == '0) ? (RegW + 1)'(1) : (RegW + 1)'(b_span_ff);
      den1_lin = den1_sq;
   end

   logic             q1_v, q1_v2;
   logic [QuoW-1:0]  q1_sq, q1_lin;
   logic [QuoW*2-1:0] q1_side, q1_side2;
   tsp_pkg::tag_type s1_tag;
   logic [RegW:0]    s1_d;

   tsp_div u_div_sq (
      .clock(clock), .reset(reset), .in_valid(b_v_ff),
      .in_num(cru ? '0 : b_sq_ff), .in_den(den1_sq),
      .in_side((QuoW * 2)'({b_tag_ff, b_d_ff})),
      .out_valid(q1_v), .out_quo(q1_sq), .out_side(q1_side));
   tsp_div u_div_lin (
      .clock(clock), .reset(reset), .in_valid(b_v_ff),
      .in_num(cru ? '0 : b_lin_ff), .in_den(den1_lin), .in_side('0),
      .out_valid(q1_v2), .out_quo(q1_lin), .out_side(q1_side2));

   assign {s1_tag, s1_d} = q1_side[4 + RegW:0];

   // Stage C: scale by One for the second division.
   logic             c_v_ff;
   logic [NumW-1:0]  c_dn_ff, c_vn_ff;
   logic [RegW:0]    c_d_ff;
   tsp_pkg::tag_type c_tag_ff;
   logic [NumW-1:0]  cru_pipe_dn, cru_pipe_vn;
   // Carrying the cruise numerators through the divider side channel would be
   // wide; instead the cruise numerator from stage B, computed from t and t1,
   // is kept in a parallel delay line.
   logic [NumW-1:0]  cru_ff [QuoW+1];
   always_ff @(posedge clock) begin
      cru_ff[0] <= b_cru_ff;
      for (int i = 0; i < QuoW; i++) begin
         cru_ff[i+1] <= cru_ff[i];
      end
   end
   assign cru_pipe_dn = cru_ff[QuoW];
   assign cru_pipe_vn = NumW'(1) << (2 * Fb + 1);

   always_ff @(posedge clock) begin
      if (s1_tag.phase == tsp_pkg::PhaseCruise) begin
         c_dn_ff <= cru_pipe_dn;
         c_vn_ff <= cru_pipe_vn;
      end else begin
         c_dn_ff <= NumW'(q1_sq) << Fb;
         c_vn_ff <= NumW'(q1_lin) << Fb;
      end
      c_d_ff   <= s1_d;
      c_tag_ff <= s1_tag;
      if (reset) begin
         c_v_ff <= 1'b0;
      end else begin
         c_v_ff <= q1_v;
      end
   end

   logic             q2_v, q2_v2;
   logic [QuoW-1:0]  q2_d, q2_vel;
   logic [QuoW*2-1:0] q2_side, q2_side2;
   tsp_pkg::tag_type s2_tag;

   tsp_div u_div_dist (
      .clock(clock), .reset(reset), .in_valid(c_v_ff),
      .in_num(c_dn_ff), .in_den(c_d_ff), .in_side((QuoW * 2)'(c_tag_ff)),
      .out_valid(q2_v), .out_quo(q2_d), .out_side(q2_side));
   tsp_div u_div_vel (
      .clock(clock), .reset(reset), .in_valid(c_v_ff),
      .in_num(c_vn_ff), .in_den(c_d_ff), .in_side('0),
      .out_valid(q2_v2), .out_quo(q2_vel), .out_side(q2_side2));

   assign s2_tag = q2_side[3:0];

   // Output stage: special cases and saturation.
   logic [RegW-1:0] dist_ff, vel_ff;
   logic [1:0]      ph_ff;
   logic            err_ff, ov_ff;
   always_ff @(posedge clock) begin
      if (s2_tag.cfg_err) begin
         dist_ff <= '0;
         vel_ff  <= '0;
         ph_ff   <= tsp_pkg::PhaseAccel;
      end else begin
         ph_ff <= s2_tag.phase;
         if (s2_tag.phase == tsp_pkg::PhaseDecel) begin
            if (s2_tag.span_zero) begin
               dist_ff <= tsp_pkg::One;
               vel_ff  <= '0;
            end else begin
               dist_ff <= RegW'(QuoW'(tsp_pkg::One) - q2_d);
               vel_ff  <= (q2_vel > QuoW'(tsp_pkg::VelMax)) ? tsp_pkg::VelMax
                                                           : RegW'(q2_vel);
            end
         end else begin
            dist_ff <= RegW'(q2_d);
            vel_ff  <= (q2_vel > QuoW'(tsp_pkg::VelMax)) ? tsp_pkg::VelMax
                                                        : RegW'(q2_vel);
         end
      end
      err_ff <= s2_tag.cfg_err;
      if (reset) begin
         ov_ff <= 1'b0;
      end else begin
         ov_ff <= q2_v;
      end
   end

   assign rsp_valid        = ov_ff;
   assign rsp_distance     = dist_ff;
   assign rsp_velocity     = vel_ff;
   assign rsp_phase        = ph_ff;
   assign rsp_config_error = err_ff;

   logic unused_ok;
   assign unused_ok = ^{q1_v2, q2_v2, q1_side2, q2_side2, q2_side, q1_side};

`ifndef SYNTHESIS
   a_pair1: assert property (@(posedge clock) disable iff (reset) q1_v == q1_v2)
      else $error("dividers out of step");
   a_pair2: assert property (@(posedge clock) disable iff (reset) q2_v == q2_v2)
      else $error("second dividers out of step");
   a_err: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_config_error |-> rsp_distance == '0 && rsp_velocity == '0)
      else $error("error result not zero");
   a_ph: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_phase != 2'd3)
      else $error("bad phase");
`endif
endmodule
`default_nettype wire

[hdl/tsp_div.sv]
`default_nettype none
// Pipelined restoring divider: one quotient bit per stage, each stage registered.
// The quotient is truncated to QuoW bits.
module tsp_div (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              in_valid,
   input  wire logic [tsp_pkg::NumW-1:0]          in_num,
   input  wire logic [tsp_pkg::RegW:0]            in_den,
   input  wire logic [tsp_pkg::QuoW*2-1:0]        in_side,
   output logic                                   out_valid,
   output logic [tsp_pkg::QuoW-1:0]               out_quo,
   output logic [tsp_pkg::QuoW*2-1:0]             out_side
);
   localparam int N = tsp_pkg::QuoW;
   localparam int RW = tsp_pkg::NumW + 1;

   logic [N:0]                   v_ff;
   logic [RW-1:0]                rem_ff  [N+1];
   logic [tsp_pkg::RegW:0]       den_ff  [N+1];
   logic [N-1:0]                 quo_ff  [N+1];
   logic [N*2-1:0]               side_ff [N+1];

   always_ff @(posedge clock) begin
      rem_ff[0]  <= RW'(in_num);
      den_ff[0]  <= in_den;
      quo_ff[0]  <= '0;
      side_ff[0] <= in_side;
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else begin
         v_ff[0] <= in_valid;
      end
   end

   for (genvar s = 0; s < N; s++) begin : g_stage
      localparam int Sh = N - 1 - s;
      logic [RW+N-1:0] trial;
      logic            fit;
      always_comb begin
         trial = (RW + N)'(den_ff[s]) << Sh;
         fit = (RW + N)'(rem_ff[s]) >= trial;
      end
      always_ff @(posedge clock) begin
         rem_ff[s+1]  <= fit ? RW'((RW + N)'(rem_ff[s]) - trial) : rem_ff[s];
         den_ff[s+1]  <= den_ff[s];
         quo_ff[s+1]  <= quo_ff[s] | (N'(fit) << Sh);
         side_ff[s+1] <= side_ff[s];
         if (reset) begin
            v_ff[s+1] <= 1'b0;
         end else begin
            v_ff[s+1] <= v_ff[s];
         end
      end
   end

   assign out_valid = v_ff[N];
   assign out_quo   = quo_ff[N];
   assign out_side  = side_ff[N];
endmodule
`default_nettype wire
